>>> rtl/core/rsfr_pkg.sv
// Shared types, codes and reset defaults for the RS-485 frame receiver and slot transmitter.
package rsfr_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;

    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [7:0] SOF_BYTE       = 8'hC3;
    localparam logic [7:0] SYNC_LEN       = 8'd1;
    localparam logic [7:0] MIN_STD_LEN    = 8'd4;
    localparam logic [7:0] HDR_ADDR_BYTES = 8'd2;
    localparam logic [7:0] BCAST_ADDR     = 8'd0;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NODE_ADDR     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOT_TICKS    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREE_RUN      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RX_TIMEOUT    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_DELAY   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_FRAME_LEN = 3'd5;

    // register reset values
    localparam logic [7:0]  NODE_ADDR_RST     = 8'hFF;
    localparam logic [3:0]  SLOT_TICKS_RST    = 4'd2;
    localparam logic [15:0] FREE_RUN_RST      = 16'd512;
    localparam logic [15:0] RX_TIMEOUT_RST    = 16'd40;
    localparam logic [15:0] START_DELAY_RST   = 16'd256;
    localparam logic [7:0]  MAX_FRAME_LEN_RST = 8'd66;

    // item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result event codes
    localparam logic [2:0] EV_PAYLOAD   = 3'd0;
    localparam logic [2:0] EV_GOOD      = 3'd1;
    localparam logic [2:0] EV_BAD_SUM   = 3'd2;
    localparam logic [2:0] EV_TIMEOUT   = 3'd3;
    localparam logic [2:0] EV_SEND_DATA = 3'd4;
    localparam logic [2:0] EV_SEND_SYNC = 3'd5;
    localparam logic [2:0] EV_TX_DONE   = 3'd6;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_BUSY = 5'b01000,
        PH_TX   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_len;
        logic [7:0] source_addr;
    } result_t;

endpackage

>>> rtl/core/rsfr_out_skid.sv
// Result register with one skid entry between the item logic and the output channel.
module rsfr_out_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rsfr_pkg::result_t push_res,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output rsfr_pkg::result_t out_res
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    rsfr_pkg::result_t out_res_reg;
    rsfr_pkg::result_t out_res_next;
    rsfr_pkg::result_t skid_res_reg;
    rsfr_pkg::result_t skid_res_next;
    logic              drain;

    assign drain = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            // refill the output from the skid entry once it drains
            if (drain)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || drain)
            begin
                out_res_next   = push_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (drain)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed while skid entry is full");

    a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output on transfer");

endmodule

>>> rtl/core/rs485_frame_rx_slot_tx.sv
// Top level: RS-485 frame deframer, receive watchdog and token-slot transmit timer.
// Results are registered in the output register, or in the skid entry while that is occupied.
// Throughput: one item per cycle unless stalled; each is a single state update at transfer.
// in_stall rises only while the one-entry skid behind the output register is full.
// Reset (rst_n, asynchronous): receiver idle, counters zero, registers at defaults,
// transmit limit at the start delay; output channel empty.
module rs485_frame_rx_slot_tx
#(
    parameter int TIMER_WIDTH = rsfr_pkg::TIMER_WIDTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rsfr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rsfr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [7:0]                           rx_byte,
    input  logic                                 tx_pending,
    input  logic                                 line_free,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           event_res,
    output logic [7:0]                           data_byte,
    output logic [7:0]                           byte_index,
    output logic [7:0]                           payload_len,
    output logic [7:0]                           source_addr
);

    localparam int EXT_W = 33;
    localparam logic [EXT_W-1:0] TMAX_EXT = (EXT_W'(1) << TIMER_WIDTH) - EXT_W'(1);

    function automatic logic [TIMER_WIDTH-1:0] sat_timer(input logic [EXT_W-1:0] v);
        logic [TIMER_WIDTH-1:0] r;
        if (v > TMAX_EXT)
            r = '1;
        else
            r = v[TIMER_WIDTH-1:0];
        return r;
    endfunction

    // configuration registers
    logic [7:0]  node_addr_reg;
    logic [3:0]  slot_ticks_reg;
    logic [15:0] free_run_reg;
    logic [15:0] rx_timeout_reg;
    logic [7:0]  max_len_reg;

    // link state
    rsfr_pkg::phase_t       phase_reg,    phase_next;
    logic [7:0]             position_reg, position_next;
    logic [7:0]             frame_len_reg, frame_len_next;
    logic [7:0]             sum_reg,      sum_next;
    logic [7:0]             sender_reg,   sender_next;
    logic [7:0]             slot_off_reg, slot_off_next;
    logic [TIMER_WIDTH-1:0] rx_elapsed_reg, rx_elapsed_next;
    logic [TIMER_WIDTH-1:0] tx_elapsed_reg, tx_elapsed_next;
    logic [TIMER_WIDTH-1:0] tx_limit_reg,   tx_limit_next;
    logic                   start_delay_on_reg, start_delay_on_next;

    logic                   in_accept;
    logic                   res_valid;
    rsfr_pkg::result_t      res;
    rsfr_pkg::result_t      out_res;
    logic                   skid_full;
    logic [7:0]             sum_add;
    logic [7:0]             slot_off_new;
    logic [11:0]            slot_prod;
    logic [TIMER_WIDTH-1:0] tx_inc;
    logic [TIMER_WIDTH-1:0] rx_inc;
    logic                   tx_expired;
    logic                   rx_expired;

    assign in_accept    = in_valid && !in_stall;
    assign sum_add      = sum_reg + rx_byte;
    assign slot_off_new = node_addr_reg - rx_byte;
    // slot offset comes from the header byte when a sync frame reloads right away
    assign slot_prod    = ((phase_reg == rsfr_pkg::PH_HDR) ? slot_off_new : slot_off_reg)
                          * slot_ticks_reg;
    assign tx_inc       = (tx_elapsed_reg == '1) ? tx_elapsed_reg
                                                 : tx_elapsed_reg + TIMER_WIDTH'(1);
    assign rx_inc       = (rx_elapsed_reg == '1) ? rx_elapsed_reg
                                                 : rx_elapsed_reg + TIMER_WIDTH'(1);
    assign tx_expired   = tx_inc > tx_limit_reg;
    assign rx_expired   = {{(EXT_W-TIMER_WIDTH){1'b0}}, rx_inc} > {17'b0, rx_timeout_reg};

    always_comb
    begin
        phase_next          = phase_reg;
        position_next       = position_reg;
        frame_len_next      = frame_len_reg;
        sum_next            = sum_reg;
        sender_next         = sender_reg;
        slot_off_next       = slot_off_reg;
        rx_elapsed_next     = rx_elapsed_reg;
        tx_elapsed_next     = tx_elapsed_reg;
        tx_limit_next       = tx_limit_reg;
        start_delay_on_next = start_delay_on_reg;
        res_valid           = 1'b0;
        res.event_res       = rsfr_pkg::EV_PAYLOAD;
        res.data_byte       = 8'd0;
        res.byte_index      = 8'd0;
        res.payload_len     = 8'd0;

        if (in_accept && req_type == rsfr_pkg::REQ_BYTE)
        begin
            unique case (phase_reg)
                rsfr_pkg::PH_IDLE:
                begin
                    if (rx_byte == rsfr_pkg::SOF_BYTE)
                    begin
                        rx_elapsed_next = '0;
                        phase_next      = rsfr_pkg::PH_HDR;
                        position_next   = 8'd0;
                    end
                end
                rsfr_pkg::PH_HDR:
                begin
                    if (position_reg == 8'd0)
                    begin
                        if (rx_byte == rsfr_pkg::SYNC_LEN ||
                            (rx_byte >= rsfr_pkg::MIN_STD_LEN && rx_byte < max_len_reg))
                        begin
                            position_next  = 8'd1;
                            frame_len_next = rx_byte;
                            sum_next       = rx_byte;
                        end
                        else
                        begin
                            phase_next = rsfr_pkg::PH_IDLE;
                        end
                    end
                    else if (position_reg == 8'd1)
                    begin
                        sender_next   = rx_byte;
                        slot_off_next = slot_off_new;
                        if (frame_len_reg == rsfr_pkg::SYNC_LEN)
                        begin
                            tx_elapsed_next     = '0;
                            tx_limit_next       = sat_timer(EXT_W'(slot_prod));
                            start_delay_on_next = 1'b0;
                            phase_next          = rsfr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            position_next = 8'd2;
                            sum_next      = sum_add;
                        end
                    end
                    else
                    begin
                        sum_next = sum_add;
                        if (rx_byte == node_addr_reg || rx_byte == rsfr_pkg::BCAST_ADDR)
                        begin
                            phase_next     = rsfr_pkg::PH_DATA;
                            position_next  = 8'd0;
                            frame_len_next = frame_len_reg - rsfr_pkg::HDR_ADDR_BYTES;
                        end
                        else
                        begin
                            phase_next = rsfr_pkg::PH_BUSY;
                        end
                    end
                end
                rsfr_pkg::PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (position_reg < frame_len_reg)
                    begin
                        position_next  = position_reg + 8'd1;
                        sum_next       = sum_add;
                        res.event_res  = rsfr_pkg::EV_PAYLOAD;
                        res.data_byte  = rx_byte;
                        res.byte_index = position_reg;
                    end
                    else
                    begin
                        phase_next = rsfr_pkg::PH_IDLE;
                        if (rx_byte == sum_reg)
                        begin
                            tx_elapsed_next     = '0;
                            tx_limit_next       = sat_timer(EXT_W'(slot_prod));
                            start_delay_on_next = 1'b0;
                            res.event_res       = rsfr_pkg::EV_GOOD;
                            res.payload_len     = frame_len_reg;
                        end
                        else
                        begin
                            res.event_res = rsfr_pkg::EV_BAD_SUM;
                        end
                    end
                end
                rsfr_pkg::PH_BUSY:
                begin
                    // count through a frame for another node
                    if (position_reg < frame_len_reg)
                    begin
                        position_next = position_reg + 8'd1;
                        sum_next      = sum_add;
                    end
                    else
                    begin
                        if (rx_byte == sum_reg)
                        begin
                            tx_elapsed_next     = '0;
                            tx_limit_next       = sat_timer(EXT_W'(slot_prod));
                            start_delay_on_next = 1'b0;
                        end
                        phase_next = rsfr_pkg::PH_IDLE;
                    end
                end
                rsfr_pkg::PH_TX:
                begin
                    // drop own echo
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            tx_elapsed_next = tx_inc;
            rx_elapsed_next = rx_inc;
            unique case (phase_reg)
                rsfr_pkg::PH_IDLE:
                begin
                    if (tx_expired && line_free)
                    begin
                        tx_elapsed_next     = '0;
                        tx_limit_next       = sat_timer({17'b0, free_run_reg});
                        start_delay_on_next = 1'b0;
                        res_valid           = 1'b1;
                        if (tx_pending)
                        begin
                            phase_next    = rsfr_pkg::PH_TX;
                            res.event_res = rsfr_pkg::EV_SEND_DATA;
                        end
                        else
                        begin
                            res.event_res = rsfr_pkg::EV_SEND_SYNC;
                        end
                    end
                end
                rsfr_pkg::PH_TX:
                begin
                    if (line_free)
                    begin
                        phase_next    = rsfr_pkg::PH_IDLE;
                        res_valid     = 1'b1;
                        res.event_res = rsfr_pkg::EV_TX_DONE;
                    end
                end
                rsfr_pkg::PH_HDR, rsfr_pkg::PH_DATA, rsfr_pkg::PH_BUSY:
                begin
                    if (rx_expired)
                    begin
                        phase_next    = rsfr_pkg::PH_IDLE;
                        res_valid     = 1'b1;
                        res.event_res = rsfr_pkg::EV_TIMEOUT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // a start delay write retargets the limit until the first grant or reload
        if (cfg_write && cfg_index == rsfr_pkg::REG_START_DELAY && start_delay_on_reg)
        begin
            tx_limit_next = sat_timer({17'b0, cfg_data});
        end

        res.source_addr = sender_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg   <= rsfr_pkg::NODE_ADDR_RST;
            slot_ticks_reg  <= rsfr_pkg::SLOT_TICKS_RST;
            free_run_reg    <= rsfr_pkg::FREE_RUN_RST;
            rx_timeout_reg  <= rsfr_pkg::RX_TIMEOUT_RST;
            max_len_reg     <= rsfr_pkg::MAX_FRAME_LEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rsfr_pkg::REG_NODE_ADDR:     node_addr_reg   <= cfg_data[7:0];
                rsfr_pkg::REG_SLOT_TICKS:    slot_ticks_reg  <= cfg_data[3:0];
                rsfr_pkg::REG_FREE_RUN:      free_run_reg    <= cfg_data;
                rsfr_pkg::REG_RX_TIMEOUT:    rx_timeout_reg  <= cfg_data;
                rsfr_pkg::REG_START_DELAY:
                begin
                    // only acts on the transmit limit
                end
                rsfr_pkg::REG_MAX_FRAME_LEN: max_len_reg     <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= rsfr_pkg::PH_IDLE;
            position_reg       <= 8'd0;
            frame_len_reg      <= 8'd0;
            sum_reg            <= 8'd0;
            sender_reg         <= 8'd0;
            slot_off_reg       <= 8'd0;
            rx_elapsed_reg     <= '0;
            tx_elapsed_reg     <= '0;
            tx_limit_reg       <= sat_timer({17'b0, rsfr_pkg::START_DELAY_RST});
            start_delay_on_reg <= 1'b1;
        end
        else
        begin
            phase_reg          <= phase_next;
            position_reg       <= position_next;
            frame_len_reg      <= frame_len_next;
            sum_reg            <= sum_next;
            sender_reg         <= sender_next;
            slot_off_reg       <= slot_off_next;
            rx_elapsed_reg     <= rx_elapsed_next;
            tx_elapsed_reg     <= tx_elapsed_next;
            tx_limit_reg       <= tx_limit_next;
            start_delay_on_reg <= start_delay_on_next;
        end
    end

    rsfr_out_skid u_out_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign in_stall    = skid_full;
    assign event_res   = out_res.event_res;
    assign data_byte   = out_res.data_byte;
    assign byte_index  = out_res.byte_index;
    assign payload_len = out_res.payload_len;
    assign source_addr = out_res.source_addr;

    a_data_grant_enters_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == rsfr_pkg::EV_SEND_DATA) |=> phase_reg == rsfr_pkg::PH_TX)
        else $error("data send granted without entering transmit phase");

    a_grant_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.event_res == rsfr_pkg::EV_SEND_DATA ||
                       res.event_res == rsfr_pkg::EV_SEND_SYNC)) |=> tx_elapsed_reg == '0)
        else $error("transmit timer not restarted on grant");

    a_payload_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == rsfr_pkg::EV_PAYLOAD) |-> phase_reg == rsfr_pkg::PH_DATA)
        else $error("payload byte reported outside data phase");

endmodule

>>> verif/rsfr_checker.sv
// Scoreboard for the RS-485 frame receiver: predicts every event and compares the output stream.
module rsfr_checker
    import rsfr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       req_type,
    input  logic [7:0]                 rx_byte,
    input  logic                       tx_pending,
    input  logic                       line_free,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [2:0]                 event_res,
    input  logic [7:0]                 data_byte,
    input  logic [7:0]                 byte_index,
    input  logic [7:0]                 payload_len,
    input  logic [7:0]                 source_addr,
    output int                         fail_count,
    output int                         expected_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = TIMER_WIDTH_DEFAULT;
    localparam longint unsigned TIMER_MAX = (64'd1 << TW) - 64'd1;

    // register copies
    logic [7:0]    r_node;
    logic [3:0]    r_slot;
    logic [15:0]   r_free;
    logic [15:0]   r_rxto;
    logic [7:0]    r_maxlen;

    // link state
    phase_t        link_phase;
    logic [7:0]    frm_pos;
    logic [7:0]    frm_len;
    logic [7:0]    frm_sum;
    logic [7:0]    frm_src;
    logic [7:0]    slot_off;
    logic [TW-1:0] rx_age;
    logic [TW-1:0] tx_age;
    logic [TW-1:0] tx_lim;
    bit            start_hold;

    result_t       pending_events[$];

    function automatic logic [TW-1:0] timer_sat(longint unsigned v);
        return (v > TIMER_MAX) ? TW'(TIMER_MAX) : TW'(v);
    endfunction

    task automatic reset_link();
        r_node     = NODE_ADDR_RST;
        r_slot     = SLOT_TICKS_RST;
        r_free     = FREE_RUN_RST;
        r_rxto     = RX_TIMEOUT_RST;
        r_maxlen   = MAX_FRAME_LEN_RST;
        link_phase = PH_IDLE;
        frm_pos    = '0;
        frm_len    = '0;
        frm_sum    = '0;
        frm_src    = '0;
        slot_off   = '0;
        rx_age     = '0;
        tx_age     = '0;
        tx_lim     = timer_sat(64'(START_DELAY_RST));
        start_hold = 1'b1;
    endtask

    task automatic restart_slot();
        tx_age     = '0;
        tx_lim     = timer_sat(64'(slot_off) * 64'(r_slot));
        start_hold = 1'b0;
    endtask

    task automatic post_event(logic [2:0] ev, logic [7:0] db, logic [7:0] idx, logic [7:0] len);
        result_t r;
        r.event_res   = ev;
        r.data_byte   = db;
        r.byte_index  = idx;
        r.payload_len = len;
        r.source_addr = frm_src;
        pending_events.push_back(r);
    endtask

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                  logic [CFG_DATA_WIDTH-1:0] data);
        case (idx)
            REG_NODE_ADDR:     r_node = data[7:0];
            REG_SLOT_TICKS:    r_slot = data[3:0];
            REG_FREE_RUN:      r_free = data[15:0];
            REG_RX_TIMEOUT:    r_rxto = data[15:0];
            REG_START_DELAY:
            begin
                // only reaches the timer until the first grant or reload
                if (start_hold)
                    tx_lim = timer_sat(64'(data[15:0]));
            end
            REG_MAX_FRAME_LEN: r_maxlen = data[7:0];
            default: ;
        endcase
    endtask

    task automatic take_byte(logic [7:0] ch);
        case (link_phase)
            PH_IDLE:
            begin
                if (ch == SOF_BYTE)
                begin
                    rx_age     = '0;
                    link_phase = PH_HDR;
                    frm_pos    = '0;
                end
            end
            PH_HDR:
            begin
                if (frm_pos == 8'd0)
                begin
                    if (ch == SYNC_LEN || (ch >= MIN_STD_LEN && ch < r_maxlen))
                    begin
                        frm_pos = 8'd1;
                        frm_len = ch;
                        frm_sum = ch;
                    end
                    else
                        link_phase = PH_IDLE;
                end
                else if (frm_pos == 8'd1)
                begin
                    frm_src  = ch;
                    slot_off = r_node - ch;
                    if (frm_len == SYNC_LEN)
                    begin
                        restart_slot();
                        link_phase = PH_IDLE;
                    end
                    else
                    begin
                        frm_pos = 8'd2;
                        frm_sum = frm_sum + ch;
                    end
                end
                else
                begin
                    frm_sum = frm_sum + ch;
                    if (ch == r_node || ch == BCAST_ADDR)
                    begin
                        link_phase = PH_DATA;
                        frm_pos    = '0;
                        frm_len    = frm_len - HDR_ADDR_BYTES;
                    end
                    else
                        link_phase = PH_BUSY;
                end
            end
            PH_DATA:
            begin
                if (frm_pos < frm_len)
                begin
                    post_event(EV_PAYLOAD, ch, frm_pos, 8'd0);
                    frm_pos = frm_pos + 8'd1;
                    frm_sum = frm_sum + ch;
                end
                else
                begin
                    link_phase = PH_IDLE;
                    if (ch == frm_sum)
                    begin
                        restart_slot();
                        post_event(EV_GOOD, 8'd0, 8'd0, frm_len);
                    end
                    else
                        post_event(EV_BAD_SUM, 8'd0, 8'd0, 8'd0);
                end
            end
            PH_BUSY:
            begin
                // foreign frame: count through, a good sum still reloads the slot
                if (frm_pos < frm_len)
                begin
                    frm_pos = frm_pos + 8'd1;
                    frm_sum = frm_sum + ch;
                end
                else
                begin
                    if (ch == frm_sum)
                        restart_slot();
                    link_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    endtask

    task automatic take_tick(bit pend, bit free);
        tx_age = timer_sat(64'(tx_age) + 64'd1);
        rx_age = timer_sat(64'(rx_age) + 64'd1);
        if (link_phase == PH_IDLE)
        begin
            if (tx_age > tx_lim && free)
            begin
                tx_age     = '0;
                tx_lim     = timer_sat(64'(r_free));
                start_hold = 1'b0;
                if (pend)
                begin
                    link_phase = PH_TX;
                    post_event(EV_SEND_DATA, 8'd0, 8'd0, 8'd0);
                end
                else
                    post_event(EV_SEND_SYNC, 8'd0, 8'd0, 8'd0);
            end
        end
        else if (link_phase == PH_TX)
        begin
            if (free)
            begin
                link_phase = PH_IDLE;
                post_event(EV_TX_DONE, 8'd0, 8'd0, 8'd0);
            end
        end
        else if (64'(rx_age) > 64'(r_rxto))
        begin
            link_phase = PH_IDLE;
            post_event(EV_TIMEOUT, 8'd0, 8'd0, 8'd0);
        end
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_event();
        result_t want;
        if (pending_events.size() == 0)
        begin
            $error("event_res: expected none, got %0d", event_res);
            fail_count++;
        end
        else
        begin
            want = pending_events.pop_front();
            compare_field("event_res", 8'(want.event_res), 8'(event_res));
            compare_field("data_byte", want.data_byte, data_byte);
            compare_field("byte_index", want.byte_index, byte_index);
            compare_field("payload_len", want.payload_len, payload_len);
            compare_field("source_addr", want.source_addr, source_addr);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_link();
            pending_events.delete();
            fail_count     = 0;
            expected_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_event();
            if (cfg_write)
                write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_BYTE)
                    take_byte(rx_byte);
                else
                    take_tick(tx_pending, line_free);
            end
            expected_count = pending_events.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Top of the frame receiver testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsfr_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       req_type;
    logic [7:0]                 rx_byte;
    logic                       tx_pending;
    logic                       line_free;
    logic                       out_valid;
    logic                       out_stall;
    logic [2:0]                 event_res;
    logic [7:0]                 data_byte;
    logic [7:0]                 byte_index;
    logic [7:0]                 payload_len;
    logic [7:0]                 source_addr;
    int                         fail_count;
    int                         expected_count;

    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         hold_cycles;
    int                         n_items;
    int                         n_ignored;
    logic [7:0]                 cur_node;
    logic [7:0]                 cur_maxlen;

    rs485_frame_rx_slot_tx DUT (.*);

    rsfr_checker checker_i (.*);

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: random stalls, or a counted hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(logic kind, logic [7:0] b, logic pend, logic free);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= kind;
        rx_byte    <= b;
        tx_pending <= pend;
        line_free  <= free;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(REQ_BYTE, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_tick(logic pend, logic free);
        send_item(REQ_TICK, 8'($urandom_range(255)), pend, free);
    endtask

    task automatic random_tick();
        send_tick(1'($urandom_range(1)), $urandom_range(99) < 80);
    endtask

    // hold the sender until every expected event has been transferred
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(logic [7:0] node, logic [3:0] slot, logic [15:0] free_run,
                             logic [15:0] rx_to, logic [15:0] start_dly, logic [7:0] maxlen);
        write_reg(REG_NODE_ADDR, 16'(node));
        write_reg(REG_SLOT_TICKS, 16'(slot));
        write_reg(REG_FREE_RUN, free_run);
        write_reg(REG_RX_TIMEOUT, rx_to);
        write_reg(REG_START_DELAY, start_dly);
        write_reg(REG_MAX_FRAME_LEN, 16'(maxlen));
        cur_node   = node;
        cur_maxlen = maxlen;
    endtask

    // mostly a source a few slots below our address, so the slot timer expires soon
    function automatic logic [7:0] near_src();
        if ($urandom_range(99) < 80)
            return cur_node - 8'($urandom_range(4));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_frame(int len, logic [7:0] src, logic [7:0] dst, bit bad_sum, int tick_pct);
        logic [7:0] chk;
        logic [7:0] b;
        send_byte(SOF_BYTE);
        send_byte(8'(len));
        send_byte(src);
        send_byte(dst);
        chk = 8'(len) + src + dst;
        for (int i = 0; i < len - 2; i++)
        begin
            b   = 8'($urandom_range(255));
            chk = chk + b;
            if ($urandom_range(99) < tick_pct)
                repeat ($urandom_range(3, 1)) random_tick();
            send_byte(b);
        end
        if (bad_sum)
            chk = chk + 8'($urandom_range(255, 1));
        send_byte(chk);
    endtask

    task automatic random_traffic(int target);
        int         base;
        int         pick;
        int         hi;
        logic [7:0] dst;
        logic [7:0] bad_len;
        base = n_items - n_ignored;
        while (n_items - n_ignored - base < target)
        begin
            pick = $urandom_range(99);
            hi   = int'(cur_maxlen) - 1;
            if (hi > 12)
                hi = 12;
            if (pick < 40)
            begin
                case ($urandom_range(2))
                    0:       dst = cur_node;
                    1:       dst = BCAST_ADDR;
                    default: dst = 8'($urandom_range(255));
                endcase
                send_frame($urandom_range(hi, 4), near_src(), dst, $urandom_range(99) < 15, 8);
            end
            else if (pick < 55)
            begin
                send_byte(SOF_BYTE);
                send_byte(SYNC_LEN);
                send_byte(near_src());
            end
            else if (pick < 72)
                repeat ($urandom_range(20, 1)) random_tick();
            else if (pick < 82)
            begin
                send_byte(SOF_BYTE);
                if ($urandom_range(1) == 0)
                begin
                    case ($urandom_range(3))
                        0:       bad_len = 8'd0;
                        1:       bad_len = 8'($urandom_range(3, 2));
                        2:       bad_len = 8'($urandom_range(255, cur_maxlen));
                        default: bad_len = 8'hFF;
                    endcase
                    send_byte(bad_len);
                end
                else
                begin
                    // truncated header, then let the watchdog see some ticks
                    send_byte(8'($urandom_range(hi, 4)));
                    send_byte(near_src());
                    repeat ($urandom_range(10, 1)) random_tick();
                end
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                begin
                    send_byte(8'($urandom_range(255)));
                    n_ignored++;
                end
            end
            if ($urandom_range(99) < 2)
                drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = REQ_BYTE;
        rx_byte       = '0;
        tx_pending    = 1'b0;
        line_free     = 1'b0;
        hold_cycles   = 0;
        n_items       = 0;
        n_ignored     = 0;
        send_idle_pct = 23;
        recv_idle_pct = 76;
        cur_node      = NODE_ADDR_RST;
        cur_maxlen    = MAX_FRAME_LEN_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: start delay still pending, so the write reaches the timer
        configure(8'h20, 4'd1, 16'd3, 16'd3, 16'd1, 8'd66);
        send_byte(8'h55);
        send_byte(SOF_BYTE);
        send_byte(8'd2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_byte(SOF_BYTE);
        send_byte(SYNC_LEN);
        send_byte(8'h1F);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_byte(SOF_BYTE);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_frame(4, 8'h1F, 8'h20, 1'b0, 0);
        send_byte(SOF_BYTE);
        send_byte(8'd4);
        repeat (4) send_tick(1'b0, 1'b0);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p / 2)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0:       configure(8'h20, 4'd1, 16'd6, 16'd12, 16'd3, 8'd20);
                1:       configure(8'h00, 4'd15, 16'd0, 16'd0, 16'hFFFF, 8'd5);
                2:       configure(8'hFF, 4'd1, 16'hFFFF, 16'hFFFF, 16'd0, 8'd255);
                3, 4:    configure(8'($urandom_range(255)), 4'($urandom_range(15, 1)),
                                   16'($urandom_range(40)), 16'($urandom_range(60, 5)),
                                   16'($urandom_range(65535)), 8'($urandom_range(80, 5)));
                default: configure(8'h80, 4'd2, 16'd512, 16'd40, 16'd256, 8'd66);
            endcase
            if (p == 0)
            begin
                // long receiver hold-off while a payload-heavy frame backs up the block
                hold_cycles = 150;
                send_frame(12, near_src(), cur_node, 1'b0, 0);
            end
            if (p == 2)
                send_frame(254, near_src(), cur_node, 1'b0, 0);
            random_traffic(170);
        end
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
